FILE: sv/kbh_pkg.sv
// Shared types and constants of the key bucket hash block.
`default_nettype none

package kbh_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned StepCount = WordWidth;
    localparam int unsigned CountWidth = $clog2(StepCount);

    // Multiplier for integer keys in alternate mode.
    localparam logic [WordWidth-1:0] AltIntMult = 32'hB234_DD0B;

    // Input operation codes.
    localparam logic OperStringByte = 1'b0;
    localparam logic OperIntKey = 1'b1;

    // Hash mode codes.
    localparam logic ModeNormal = 1'b0;
    localparam logic ModeAlternate = 1'b1;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_MOD = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_ctl;

endpackage

`default_nettype wire

FILE: sv/kbh_iter.sv
// Shared bit-serial unit: 32x32 shift-add multiply or restoring remainder.
`default_nettype none

module kbh_iter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire kbh_pkg::t_iter_ctl              i_ctl,
    input  wire logic [kbh_pkg::WordWidth-1:0]   i_opa,
    input  wire logic [kbh_pkg::WordWidth-1:0]   i_opb,
    output logic                                 o_done,
    output logic [kbh_pkg::WordWidth-1:0]        o_hi,
    output logic [kbh_pkg::WordWidth-1:0]        o_lo
);

    localparam int unsigned W = kbh_pkg::WordWidth;

    logic                              r_busy;
    logic                              r_done;
    kbh_pkg::t_iter_op                 r_op;
    logic [kbh_pkg::CountWidth-1:0]    r_cnt;
    logic [W-1:0]                      r_hi;
    logic [W-1:0]                      r_lo;
    logic [W-1:0]                      r_b;

    logic          is_mul;
    logic [W:0]    trial;
    logic [W:0]    add_x;
    logic [W:0]    add_y;
    logic [W+1:0]  sum;
    logic [W:0]    mul_sel;
    logic          last_step;

    // One adder serves both operations; subtraction inverts the operand.
    always_comb begin
        is_mul = (r_op == kbh_pkg::OP_MUL);
        trial = {r_hi, r_lo[W-1]};
        add_x = is_mul ? {1'b0, r_hi} : trial;
        add_y = is_mul ? {1'b0, r_b} : ~{1'b0, r_b};
        sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, !is_mul};
        mul_sel = r_lo[0] ? sum[W:0] : {1'b0, r_hi};
        last_step = (r_cnt == kbh_pkg::CountWidth'(kbh_pkg::StepCount - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
            r_op <= kbh_pkg::OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_op <= i_ctl.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt + kbh_pkg::CountWidth'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hi <= '0;
            r_b <= (i_ctl.op == kbh_pkg::OP_MUL) ? i_opa : i_opb;
            r_lo <= (i_ctl.op == kbh_pkg::OP_MUL) ? i_opb : i_opa;
        end else if (r_busy) begin
            if (is_mul) begin
                r_hi <= mul_sel[W:1];
                r_lo <= {mul_sel[0], r_lo[W-1:1]};
            end else begin
                r_hi <= sum[W+1] ? sum[W-1:0] : trial[W-1:0];
                r_lo <= {r_lo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_hi = r_hi;
    assign o_lo = r_lo;

endmodule

`default_nettype wire

FILE: sv/key_bucket_hash.sv
// Top level of the key bucket hash block: key sequencing and result register.
`default_nettype none

// Usage: keys come in on the input channel (i_in_valid, o_in_stall). A string
// key is sent as one word per character and ends with a zero byte; an integer
// key is one word with i_operation set. Nonzero key bytes are folded into the
// running hash and give no result. A zero byte or an integer key gives one
// bucket index word on the output channel (o_out_valid, i_out_stall). The final
// step runs on one shared bit-serial unit that handles either the modulo
// (normal mode) or the multiply-high (alternate mode) at one bit per cycle. A
// result-producing word goes through the unit to the output register, and the
// next word is accepted once the result is there; an alternate-mode integer
// key uses the unit twice. A zero bucket count in normal mode skips the unit.
// o_in_stall is high while the unit is busy or a result waits for the output
// register. The output register is separate, so a new word is accepted while
// the previous result is still stalled by the receiver. The hash mode is
// written over the configuration channel, which is always ready; the user must
// write it only while the block is idle, as the block itself does not enforce
// it. Synchronous active-low reset selects normal mode, clears the running
// hash and marks the next byte as the start of a new key.
module key_bucket_hash (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [kbh_pkg::ByteWidth-1:0]  i_key_byte,
    input  wire logic [kbh_pkg::WordWidth-1:0]  i_int_key,
    input  wire logic [kbh_pkg::WordWidth-1:0]  i_bucket_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [kbh_pkg::WordWidth-1:0]       o_bucket_index,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_hash_mode
);

    localparam int unsigned W = kbh_pkg::WordWidth;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_KEY,
        ST_FINAL,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic                r_mode;
    logic [W-1:0]        r_acc, n_acc;
    logic                r_first, n_first;
    logic [W-1:0]        r_key, n_key;
    logic [W-1:0]        r_buckets, n_buckets;
    logic [W-1:0]        r_opa, n_opa;
    logic [W-1:0]        r_opb, n_opb;
    kbh_pkg::t_iter_ctl  r_ctl, n_ctl;
    logic [W-1:0]        r_result, n_result;
    logic                r_out_valid, n_out_valid;
    logic [W-1:0]        r_bucket_index, n_bucket_index;

    logic          unit_done;
    logic [W-1:0]  unit_hi;
    logic [W-1:0]  unit_lo;

    logic          in_accept;
    logic          out_free;
    logic [W-1:0]  char_ext;
    logic [W-1:0]  first_h;
    logic [W-1:0]  rot;
    logic [W-1:0]  alt_next;
    logic [W-1:0]  djb_next;
    logic [W-1:0]  end_h;
    logic [W-1:0]  scr_h;
    logic [W-1:0]  fold_h;

    kbh_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_opa   (r_opa),
        .i_opb   (r_opb),
        .o_done  (unit_done),
        .o_hi    (unit_hi),
        .o_lo    (unit_lo)
    );

    // Per-byte mixing, the end-of-key scramble and the integer-key fold are
    // all short shift/xor/add chains and stay combinational.
    always_comb begin
        char_ext = {{(W - kbh_pkg::ByteWidth){i_key_byte[kbh_pkg::ByteWidth-1]}},
                    i_key_byte};
        first_h = char_ext;
        if (r_mode == kbh_pkg::ModeAlternate) begin
            first_h = first_h ^ (first_h << 8);
            first_h = first_h ^ (first_h >> 3);
        end
        rot = {r_acc[12:0], r_acc[W-1:13]};
        alt_next = (r_acc + char_ext + W'(1)) ^ rot;
        djb_next = (r_acc << 5) + r_acc + char_ext;
        end_h = r_first ? '0 : r_acc;
        scr_h = end_h ^ (end_h << 4);
        scr_h = scr_h + (scr_h << 24);
        fold_h = unit_lo + ((unit_hi << 15) ^ r_key);
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_acc = r_acc;
        n_first = r_first;
        n_key = r_key;
        n_buckets = r_buckets;
        n_opa = r_opa;
        n_opb = r_opb;
        n_ctl = '{start: 1'b0, op: r_ctl.op};
        n_result = r_result;
        n_out_valid = r_out_valid && i_out_stall;
        n_bucket_index = r_bucket_index;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_key = i_int_key;
                    n_buckets = i_bucket_count;
                    if (i_operation == kbh_pkg::OperIntKey) begin
                        if (r_mode == kbh_pkg::ModeAlternate) begin
                            n_opa = i_int_key;
                            n_opb = kbh_pkg::AltIntMult;
                            n_ctl = '{start: 1'b1, op: kbh_pkg::OP_MUL};
                            n_state = ST_MUL_KEY;
                        end else if (i_bucket_count == '0) begin
                            n_result = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_opa = i_int_key;
                            n_opb = i_bucket_count;
                            n_ctl = '{start: 1'b1, op: kbh_pkg::OP_MOD};
                            n_state = ST_FINAL;
                        end
                    end else if (i_key_byte == '0) begin
                        // End of a string key: finish it and start afresh.
                        n_acc = '0;
                        n_first = 1'b1;
                        if (r_mode == kbh_pkg::ModeAlternate) begin
                            n_opa = scr_h;
                            n_opb = i_bucket_count;
                            n_ctl = '{start: 1'b1, op: kbh_pkg::OP_MUL};
                            n_state = ST_FINAL;
                        end else if (i_bucket_count == '0) begin
                            n_result = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_opa = end_h;
                            n_opb = i_bucket_count;
                            n_ctl = '{start: 1'b1, op: kbh_pkg::OP_MOD};
                            n_state = ST_FINAL;
                        end
                    end else begin
                        n_first = 1'b0;
                        if (r_first) begin
                            n_acc = first_h;
                        end else if (r_mode == kbh_pkg::ModeAlternate) begin
                            n_acc = alt_next;
                        end else begin
                            n_acc = djb_next;
                        end
                    end
                end
            end
            ST_MUL_KEY: begin
                if (unit_done) begin
                    n_opa = fold_h;
                    n_opb = r_buckets;
                    n_ctl = '{start: 1'b1, op: kbh_pkg::OP_MUL};
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // Both the remainder and the high product word end in unit_hi.
                if (unit_done) begin
                    n_result = unit_hi;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_bucket_index = r_result;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode <= kbh_pkg::ModeNormal;
            r_acc <= '0;
            r_first <= 1'b1;
            r_ctl <= '{start: 1'b0, op: kbh_pkg::OP_MUL};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_hash_mode;
            end
            r_acc <= n_acc;
            r_first <= n_first;
            r_ctl <= n_ctl;
            r_out_valid <= n_out_valid;
        end
        r_key <= n_key;
        r_buckets <= n_buckets;
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_result <= n_result;
        r_bucket_index <= n_bucket_index;
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_bucket_index = r_bucket_index;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: bench/key_bucket_hash_test.sv
// Self-checking testbench for key_bucket_hash: random and directed key words against a predictor.
module key_bucket_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    // A run of this many cycles in which no word moves on any channel means the block hung.
    localparam int QuietLimit = 3000;
    // Cycles to wait after the last result before a mode write, and at the end of the run.
    localparam int SettleCycles = 100;
    localparam int RandomWords = 400;
    // The receiver holds off once, for this long, after this many results.
    localparam int HoldAfter = 30;
    localparam int HoldCycles = 400;

    typedef enum logic [1:0] {
        ENTRY_WORD,
        ENTRY_MODE,
        ENTRY_DRAIN
    } t_entry_kind;

    // One entry of the sender's schedule: a key word, a mode write, or a pause
    // that waits until every expected bucket index has come back.
    typedef struct {
        t_entry_kind                       kind;
        logic                              operation;
        logic [kbh_pkg::ByteWidth-1:0]     key_char;
        logic [kbh_pkg::WordWidth-1:0]     int_key;
        logic [kbh_pkg::WordWidth-1:0]     bucket_count;
        logic                              hash_mode;
    } t_key_entry;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic                              i_operation = kbh_pkg::OperStringByte;
    logic [kbh_pkg::ByteWidth-1:0]     i_key_byte = '0;
    logic [kbh_pkg::WordWidth-1:0]     i_int_key = '0;
    logic [kbh_pkg::WordWidth-1:0]     i_bucket_count = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [kbh_pkg::WordWidth-1:0]     o_bucket_index;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic                              i_cfg_hash_mode = kbh_pkg::ModeNormal;

    key_bucket_hash dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_key_byte      (i_key_byte),
        .i_int_key       (i_int_key),
        .i_bucket_count  (i_bucket_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_bucket_index  (o_bucket_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_hash_mode (i_cfg_hash_mode)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_key_entry                        pending_entries[$];
    logic [kbh_pkg::WordWidth-1:0]     expected_indexes[$];

    // Predictor state, reset values of the block.
    logic                              hash_mode_q = kbh_pkg::ModeNormal;
    logic [kbh_pkg::WordWidth-1:0]     running_hash_q = '0;
    logic                              key_start_q = 1'b1;

    int  mismatch_count = 0;
    int  checked_count = 0;
    int  word_total = 0;
    int  quiet_cycles = 0;
    bit  word_taken = 1'b0;
    bit  cfg_taken = 1'b0;

    // Sender and receiver pacing state.
    int  send_gap = 0;
    int  send_steady = 0;
    int  settle_count = 0;
    int  stall_left = 0;
    int  recv_steady = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    task automatic report_mismatch(input string what,
                                   input logic [kbh_pkg::WordWidth-1:0] got,
                                   input logic [kbh_pkg::WordWidth-1:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // High word of the 64-bit product: the alternate mode's bucket.
    function automatic logic [kbh_pkg::WordWidth-1:0] spread_high(
            input logic [kbh_pkg::WordWidth-1:0] h,
            input logic [kbh_pkg::WordWidth-1:0] n);
        logic [2*kbh_pkg::WordWidth-1:0] prod;
        prod = {32'd0, h} * {32'd0, n};
        return prod[2*kbh_pkg::WordWidth-1:kbh_pkg::WordWidth];
    endfunction

    // Normal mode's bucket; a zero bucket count gives bucket 0.
    function automatic logic [kbh_pkg::WordWidth-1:0] bucket_mod(
            input logic [kbh_pkg::WordWidth-1:0] h,
            input logic [kbh_pkg::WordWidth-1:0] n);
        return (n != 0) ? h % n : '0;
    endfunction

    // Folds one accepted word into the predicted state and tells whether it
    // finishes a key, and with which bucket index.
    task automatic fold_key_word(input logic op,
                                 input logic [kbh_pkg::ByteWidth-1:0] key_char,
                                 input logic [kbh_pkg::WordWidth-1:0] key,
                                 input logic [kbh_pkg::WordWidth-1:0] buckets,
                                 output logic has_index,
                                 output logic [kbh_pkg::WordWidth-1:0] index);
        logic [2*kbh_pkg::WordWidth-1:0] prod;
        logic [kbh_pkg::WordWidth-1:0]   h;
        logic [kbh_pkg::WordWidth-1:0]   c;
        logic [kbh_pkg::WordWidth-1:0]   rot;
        has_index = 1'b1;
        index = '0;
        c = {{24{key_char[7]}}, key_char};
        if (op == kbh_pkg::OperIntKey) begin
            // An integer key is hashed on its own; a string in progress stays as it is.
            if (hash_mode_q == kbh_pkg::ModeAlternate) begin
                prod = {32'd0, key} * {32'd0, kbh_pkg::AltIntMult};
                h = prod[31:0] + ((prod[63:32] << 15) ^ key);
                index = spread_high(h, buckets);
            end else begin
                index = bucket_mod(key, buckets);
            end
        end else if (key_char == '0) begin
            // The terminator: an empty key hashes to zero in both modes.
            h = key_start_q ? '0 : running_hash_q;
            if (hash_mode_q == kbh_pkg::ModeAlternate) begin
                h = h ^ (h << 4);
                h = h + (h << 24);
                index = spread_high(h, buckets);
            end else begin
                index = bucket_mod(h, buckets);
            end
            running_hash_q = '0;
            key_start_q = 1'b1;
        end else begin
            has_index = 1'b0;
            if (key_start_q) begin
                h = c;
                if (hash_mode_q == kbh_pkg::ModeAlternate) begin
                    h = h ^ (h << 8);
                    h = h ^ (h >> 3);
                end
                running_hash_q = h;
                key_start_q = 1'b0;
            end else if (hash_mode_q == kbh_pkg::ModeAlternate) begin
                h = running_hash_q;
                rot = {h[12:0], h[31:13]};
                h = h + c + 1;
                running_hash_q = h ^ rot;
            end else begin
                running_hash_q = (running_hash_q << 5) + running_hash_q + c;
            end
        end
    endtask

    // Bucket counts lean toward the edges: zero, one, the largest, and small tables.
    function automatic logic [kbh_pkg::WordWidth-1:0] pick_buckets();
        int roll;
        roll = $urandom_range(9);
        case (roll)
            0: return '0;
            1: return '1;
            2: return 32'd1;
            3, 4, 5: return $urandom_range(16, 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [kbh_pkg::WordWidth-1:0] pick_int_key();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    // Unused fields of every word carry random bits so every input bit toggles.
    task automatic push_word(input logic op, input logic [kbh_pkg::ByteWidth-1:0] key_char,
                             input logic [kbh_pkg::WordWidth-1:0] key,
                             input logic [kbh_pkg::WordWidth-1:0] buckets);
        t_key_entry e;
        e.kind = ENTRY_WORD;
        e.operation = op;
        e.key_char = key_char;
        e.int_key = key;
        e.bucket_count = buckets;
        e.hash_mode = kbh_pkg::ModeNormal;
        pending_entries.push_back(e);
        word_total++;
    endtask

    task automatic push_char(input logic [kbh_pkg::ByteWidth-1:0] key_char,
                             input logic [kbh_pkg::WordWidth-1:0] buckets);
        push_word(kbh_pkg::OperStringByte, key_char, $urandom, buckets);
    endtask

    task automatic push_int(input logic [kbh_pkg::WordWidth-1:0] key,
                            input logic [kbh_pkg::WordWidth-1:0] buckets);
        push_word(kbh_pkg::OperIntKey, 8'($urandom_range(255)), key, buckets);
    endtask

    task automatic push_control(input t_entry_kind kind, input logic mode);
        t_key_entry e;
        e.kind = kind;
        e.operation = kbh_pkg::OperStringByte;
        e.key_char = '0;
        e.int_key = '0;
        e.bucket_count = '0;
        e.hash_mode = mode;
        pending_entries.push_back(e);
    endtask

    // Gap before the next word: mostly none, some short, a few long, and now
    // and then a stretch of back-to-back words.
    function automatic int pick_send_gap();
        int roll;
        if (send_steady != 0) begin
            send_steady--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 60) begin
            send_steady = 40;
            return 0;
        end
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Sender. A word stays on the port until it is taken. Mode writes wait
    // until all results are back and the settle time has passed; drain
    // entries hold the sender until every expected result has come.
    always @(negedge i_clk) begin
        logic       next_valid;
        logic       next_cfg;
        t_key_entry head;
        next_valid = i_in_valid && !word_taken;
        next_cfg = i_cfg_valid && !cfg_taken;
        if (expected_indexes.size() == 0)
            settle_count++;
        else
            settle_count = 0;
        if (i_rst_n && !next_valid && !next_cfg) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_entries.size() != 0) begin
                head = pending_entries[0];
                case (head.kind)
                    ENTRY_WORD: begin
                        next_valid = 1'b1;
                        i_operation <= head.operation;
                        i_key_byte <= head.key_char;
                        i_int_key <= head.int_key;
                        i_bucket_count <= head.bucket_count;
                        void'(pending_entries.pop_front());
                        send_gap = pick_send_gap();
                    end
                    ENTRY_MODE: begin
                        if (settle_count >= SettleCycles) begin
                            next_cfg = 1'b1;
                            i_cfg_hash_mode <= head.hash_mode;
                            void'(pending_entries.pop_front());
                        end
                    end
                    default: begin
                        if (expected_indexes.size() == 0)
                            void'(pending_entries.pop_front());
                    end
                endcase
            end
        end
        i_in_valid <= next_valid;
        i_cfg_valid <= next_cfg;
    end

    // Receiver. Stall runs of random length, stretches with none, and one
    // long hold-off that lets the block fill and stall its input.
    always @(negedge i_clk) begin
        int roll;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && checked_count >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (recv_steady != 0) begin
            recv_steady--;
            i_out_stall <= 1'b0;
        end else begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                i_out_stall <= 1'b0;
            end else if (roll < 75) begin
                recv_steady = 50;
                i_out_stall <= 1'b0;
            end else if (roll < 95) begin
                stall_left = $urandom_range(3, 0);
                i_out_stall <= 1'b1;
            end else begin
                stall_left = $urandom_range(40, 10);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Monitor: checks results against the oldest expectation, predicts the
    // results of accepted words, tracks mode writes and watches for a hang.
    always @(posedge i_clk) begin
        logic                              has_index;
        logic [kbh_pkg::WordWidth-1:0]     want_index;
        logic                              result_taken;
        word_taken = i_rst_n && i_in_valid && !o_in_stall;
        cfg_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
        result_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (result_taken) begin
            if (expected_indexes.size() == 0) begin
                report_mismatch("unexpected bucket_index", o_bucket_index, '0);
            end else begin
                want_index = expected_indexes.pop_front();
                if (o_bucket_index !== want_index)
                    report_mismatch("bucket_index", o_bucket_index, want_index);
            end
            checked_count++;
        end
        if (cfg_taken)
            hash_mode_q = i_cfg_hash_mode;
        if (word_taken) begin
            fold_key_word(i_operation, i_key_byte, i_int_key, i_bucket_count,
                          has_index, want_index);
            if (has_index)
                expected_indexes.push_back(want_index);
        end
        if (i_rst_n) begin
            if (word_taken || cfg_taken || result_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("timeout: no word moved for %0d cycles", QuietLimit);
                $display("key_bucket_hash test failed");
                $finish;
            end
        end
    end

    initial begin
        int roll;
        int key_len;
        int int_at;
        int last_mode_at;

        // Directed part, normal mode after reset: empty key, signed characters
        // at both extremes, integer keys at the edges, zero bucket count, and
        // an integer key in the middle of a string key.
        push_char(8'h00, 32'd7);
        push_char(8'h61, $urandom);
        push_char(8'h80, $urandom);
        push_char(8'hFF, $urandom);
        push_char(8'h7F, $urandom);
        push_char(8'h01, $urandom);
        push_char(8'h00, '1);
        push_int('1, 32'd1);
        push_int('0, '1);
        push_int(32'hDEAD_BEEF, '0);
        push_char(8'h41, $urandom);
        push_char(8'h00, '0);
        push_char(8'h10, $urandom);
        push_int(32'h1234_5678, 32'd1000);
        push_char(8'h30, $urandom);
        push_char(8'h00, 32'd97);
        push_control(ENTRY_DRAIN, kbh_pkg::ModeNormal);
        // Mode switched in the middle of a key, then the same edges in alternate mode.
        push_char(8'h55, $urandom);
        push_char(8'hC3, $urandom);
        push_control(ENTRY_MODE, kbh_pkg::ModeAlternate);
        push_char(8'h66, $urandom);
        push_char(8'h00, 32'h0001_0000);
        push_char(8'h00, '1);
        push_char(8'h80, $urandom);
        push_char(8'hFF, $urandom);
        push_char(8'h00, '1);
        push_int('1, '1);
        push_int('0, 32'd5);
        push_int(32'h0123_4567, '0);
        push_char(8'h7A, $urandom);
        push_control(ENTRY_MODE, kbh_pkg::ModeNormal);
        push_char(8'h01, $urandom);
        push_char(8'h00, 32'd13);

        // Random part: mostly whole string keys with random characters, some
        // with an integer key inside, integer keys, and a share of raw noise.
        last_mode_at = 0;
        while (word_total < RandomWords) begin
            if (word_total - last_mode_at > 60) begin
                push_control(ENTRY_MODE, 1'($urandom_range(1)));
                last_mode_at = word_total;
            end
            roll = $urandom_range(99);
            if (roll < 55) begin
                key_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                   : $urandom_range(12, 0);
                int_at = ($urandom_range(4) == 0) ? $urandom_range(key_len, 0) : -1;
                for (int i = 0; i < key_len; i++) begin
                    if (i == int_at)
                        push_int(pick_int_key(), pick_buckets());
                    push_char(8'($urandom_range(255, 1)), $urandom);
                end
                push_char(8'h00, pick_buckets());
            end else if (roll < 80) begin
                push_int(pick_int_key(), pick_buckets());
            end else begin
                push_word(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom,
                          pick_buckets());
            end
            if ($urandom_range(19) == 0)
                push_control(ENTRY_DRAIN, kbh_pkg::ModeNormal);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every entry has gone out and every result has come back.
        do
            @(posedge i_clk);
        while (pending_entries.size() != 0 || i_in_valid || i_cfg_valid
               || expected_indexes.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);

        if (expected_indexes.size() != 0)
            report_mismatch("bucket_index never arrived", '0, expected_indexes[0]);
        if (mismatch_count == 0)
            $display("key_bucket_hash test passed");
        else
            $display("key_bucket_hash test failed");
        $finish;
    end

endmodule

FILE: files.f
sv/kbh_pkg.sv
sv/kbh_iter.sv
sv/key_bucket_hash.sv
bench/key_bucket_hash_test.sv
